@@ sv/ascta_pkg.sv @@
// ----------------------------------------------------------------------------
// ascta_pkg: shared types and constants for the arc start tangent block
// Kind codes, the metadata that rides along the back pipeline, angle
// constants in hundredths of a degree and the arctangent step table.
// ----------------------------------------------------------------------------
package ascta_pkg;

  // cordic depth and widths
  localparam int CORDIC_STEPS = 25;
  localparam int NORM_BITS    = 30;
  localparam int ZW           = 32;
  localparam int ANGLE_W      = 16;

  // arctangent of 2^-i in units of 1/6553600 degree
  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507, 32'sd23437865,
    32'sd11730358,  32'sd5866610,   32'sd2933484,  32'sd1466764,  32'sd733385,
    32'sd366693,    32'sd183346,    32'sd91673,    32'sd45837,    32'sd22918,
    32'sd11459,     32'sd5730,      32'sd2865,     32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45,       32'sd22
  };

  // accumulated angle limit (90 degrees) and rounding offset
  localparam logic signed [ZW-1:0] Z_MAX   = 32'sd589824000;
  localparam logic signed [ZW-1:0] Z_ROUND = 32'sd32768;

  // near-parallel and near-axis thresholds
  localparam logic [26:0] PARALLEL_SCALE = 27'd100000000;
  localparam logic [18:0] AXIS_SCALE     = 19'd500000;

  // fixed angles, hundredths of a degree
  localparam logic signed [ANGLE_W-1:0] ANG_0   = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] ANG_90  = 16'sd9000;
  localparam logic signed [ANGLE_W-1:0] ANG_180 = 16'sd18000;
  localparam logic signed [ANGLE_W-1:0] ANG_270 = 16'sd27000;

  // how the back end finishes a word
  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_CHORD,
    KIND_RADIUS
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [ANGLE_W-1:0]  fixed_angle;
    logic                       x_neg;
    logic                       y_neg;
    logic                       dot_pos;
  } meta_t;

endpackage

@@ sv/ascta_fifo.sv @@
// ----------------------------------------------------------------------------
// ascta_fifo: short queue between front and back end
// Register-based first-in first-out buffer, depth a power of two.
// ----------------------------------------------------------------------------
module ascta_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r;
  logic [AW-1:0] rd_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

endmodule

@@ sv/ascta_front.sv @@
// ----------------------------------------------------------------------------
// ascta_front: centre solve and case classification
// Seven-stage pipeline: bisector directions, cross products, centre offset,
// near-parallel and near-axis tests; hands one word per item to the queue.
// ----------------------------------------------------------------------------
module ascta_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  via_x,
  input  logic signed [COORD_BITS-1:0]  via_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic                          q_full,
  output logic                          q_push,
  output ascta_pkg::meta_t              meta,
  output logic signed [COORD_BITS:0]    wx,
  output logic signed [COORD_BITS:0]    wy,
  output logic [3*COORD_BITS+4:0]       mag_a,
  output logic [3*COORD_BITS+4:0]       mag_b
);

  localparam int C      = COORD_BITS;
  localparam int DW1    = C + 1;
  localparam int PW2    = 2*C + 2;
  localparam int DW2    = 2*C + 3;
  localparam int MW     = 3*C + 4;
  localparam int RW     = 3*C + 5;
  localparam int TW     = DW1 + 27;
  localparam int KB     = 2*C - 14;
  localparam int LW     = KB + 19;
  localparam int STAGES = 7;

  typedef struct packed {
    logic signed [DW1-1:0] dxe;
    logic signed [DW1-1:0] dye;
    logic signed [DW1-1:0] s1x;
    logic signed [DW1-1:0] s1y;
    logic signed [DW1-1:0] wx;
    logic signed [DW1-1:0] wy;
    logic                  gate;
    logic                  vxg;
    logic                  vyg;
  } carry_t;

  logic              fe;
  logic [STAGES-1:0] v_r;

  // stall the whole front only when the last word cannot enter the queue
  assign fe       = !v_r[STAGES-1] || !q_full;
  assign in_ready = fe;
  assign q_push   = v_r[STAGES-1] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (fe) v_r <= {v_r[STAGES-2:0], in_valid};
  end

  // stage 1: differences and bisector directions
  carry_t                c1_nxt, c1_r;
  logic signed [DW1-1:0] s2x_nxt, s2y_nxt, dxv_nxt, dyv_nxt;
  logic signed [DW1-1:0] s2x_r, s2y_r, dxv_r, dyv_r;

  always_comb begin
    c1_nxt.dxe  = DW1'(end_x) - DW1'(start_x);
    c1_nxt.dye  = DW1'(end_y) - DW1'(start_y);
    dxv_nxt     = DW1'(via_x) - DW1'(start_x);
    dyv_nxt     = DW1'(via_y) - DW1'(start_y);
    if (start_x == end_x) begin
      c1_nxt.s1x = DW1'(1);
      c1_nxt.s1y = '0;
    end else if (start_y == end_y) begin
      c1_nxt.s1x = '0;
      c1_nxt.s1y = DW1'(1);
    end else begin
      c1_nxt.s1x = DW1'(end_y) - DW1'(start_y);
      c1_nxt.s1y = DW1'(start_x) - DW1'(end_x);
    end
    if (via_x == end_x) begin
      s2x_nxt = DW1'(1);
      s2y_nxt = '0;
    end else if (via_y == end_y) begin
      s2x_nxt = '0;
      s2y_nxt = DW1'(1);
    end else begin
      s2x_nxt = DW1'(end_y) - DW1'(via_y);
      s2y_nxt = DW1'(via_x) - DW1'(end_x);
    end
    c1_nxt.wx = DW1'(via_x) - DW1'(start_x);
    c1_nxt.wy = DW1'(start_y) - DW1'(via_y);
    if (c1_nxt.wx == '0 && c1_nxt.wy == '0) c1_nxt.wx = DW1'(1);
    c1_nxt.gate = (start_x != end_x) && (start_y != end_y) && (via_x != end_x);
    c1_nxt.vxg  = via_x > start_x;
    c1_nxt.vyg  = via_y > start_y;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      c1_r  <= c1_nxt;
      s2x_r <= s2x_nxt;
      s2y_r <= s2y_nxt;
      dxv_r <= dxv_nxt;
      dyv_r <= dyv_nxt;
    end
  end

  // stage 2: cross-product terms
  carry_t                c2_r;
  logic signed [PW2-1:0] p1_r, p2_r, p3_r, p4_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c2_r <= c1_r;
      p1_r <= PW2'($signed(c1_r.s1x)) * PW2'(s2y_r);
      p2_r <= PW2'($signed(c1_r.s1y)) * PW2'(s2x_r);
      p3_r <= PW2'(dxv_r) * PW2'(s2y_r);
      p4_r <= PW2'(dyv_r) * PW2'(s2x_r);
    end
  end

  // stage 3: determinant and numerator
  carry_t                c3_r;
  logic signed [DW2-1:0] d_r, n_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c3_r <= c2_r;
      d_r  <= DW2'(p1_r) - DW2'(p2_r);
      n_r  <= DW2'(p3_r) - DW2'(p4_r);
    end
  end

  // stage 4: centre offset terms and near-parallel test
  logic [DW2-1:0] absd_nxt;
  logic [DW1-1:0] as1y_nxt;
  logic [TW-1:0]  par_nxt;
  logic           tiny_nxt;

  always_comb begin
    absd_nxt = d_r[DW2-1] ? DW2'(-d_r) : DW2'(d_r);
    as1y_nxt = c3_r.s1y[DW1-1] ? DW1'(-$signed(c3_r.s1y)) : DW1'(c3_r.s1y);
    par_nxt  = TW'(absd_nxt[DW1-1:0]) * TW'(ascta_pkg::PARALLEL_SCALE);
    tiny_nxt = c3_r.gate && ((absd_nxt >> DW1) == '0) && (par_nxt < TW'(as1y_nxt));
  end

  carry_t                c4_r;
  logic signed [MW-1:0]  m1_r, m2_r, m3_r, m4_r;
  logic [DW2-1:0]        absd4_r;
  logic                  dneg4_r, chord4_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c4_r     <= c3_r;
      m1_r     <= MW'(d_r) * MW'($signed(c3_r.dxe));
      m2_r     <= MW'(n_r) * MW'($signed(c3_r.s1x));
      m3_r     <= MW'(d_r) * MW'($signed(c3_r.dye));
      m4_r     <= MW'(n_r) * MW'($signed(c3_r.s1y));
      absd4_r  <= absd_nxt;
      dneg4_r  <= d_r[DW2-1];
      chord4_r <= (d_r == '0) || tiny_nxt;
    end
  end

  // stage 5: centre offset sums
  carry_t               c5_r;
  logic signed [RW-1:0] rx_r, ry_r;
  logic [DW2-1:0]       absd5_r;
  logic                 dneg5_r, chord5_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c5_r     <= c4_r;
      rx_r     <= RW'(m1_r) + RW'(m2_r);
      ry_r     <= RW'(m3_r) + RW'(m4_r);
      absd5_r  <= absd4_r;
      dneg5_r  <= dneg4_r;
      chord5_r <= chord4_r;
    end
  end

  // stage 6: magnitudes and radius direction signs
  carry_t         c6_r;
  logic [RW-1:0]  arx6_r, ary6_r;
  logic [DW2-1:0] absd6_r;
  logic           uxn6_r, uyn6_r, chord6_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c6_r     <= c5_r;
      arx6_r   <= rx_r[RW-1] ? RW'(-rx_r) : RW'(rx_r);
      ary6_r   <= ry_r[RW-1] ? RW'(-ry_r) : RW'(ry_r);
      absd6_r  <= absd5_r;
      uxn6_r   <= dneg5_r ? rx_r[RW-1] : (!rx_r[RW-1] && rx_r != '0);
      uyn6_r   <= dneg5_r ? (!ry_r[RW-1] && ry_r != '0) : ry_r[RW-1];
      chord6_r <= chord5_r;
    end
  end

  // stage 7: centre level with or straight above or below the start point
  logic [LW-1:0] lvl_prod_nxt, abv_prod_nxt;

  always_comb begin
    lvl_prod_nxt = LW'(ary6_r[KB-1:0]) * LW'(ascta_pkg::AXIS_SCALE);
    abv_prod_nxt = LW'(arx6_r[KB-1:0]) * LW'(ascta_pkg::AXIS_SCALE);
  end

  carry_t        c7_r;
  logic [RW-1:0] arx7_r, ary7_r;
  logic          uxn7_r, uyn7_r, chord7_r, lvl7_r, abv7_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      c7_r     <= c6_r;
      arx7_r   <= arx6_r;
      ary7_r   <= ary6_r;
      uxn7_r   <= uxn6_r;
      uyn7_r   <= uyn6_r;
      chord7_r <= chord6_r;
      lvl7_r   <= ((ary6_r >> KB) == '0) && (lvl_prod_nxt < LW'(absd6_r));
      abv7_r   <= ((arx6_r >> KB) == '0) && (abv_prod_nxt < LW'(absd6_r));
    end
  end

  // classify and build the queue word
  logic signed [DW1-1:0] dxe7, dye7;

  assign dxe7 = c7_r.dxe;
  assign dye7 = c7_r.dye;
  assign wx   = c7_r.wx;
  assign wy   = c7_r.wy;

  always_comb begin
    meta  = '0;
    mag_a = '0;
    mag_b = '0;
    if (chord7_r) begin
      if (dxe7 == '0) begin
        meta.kind        = ascta_pkg::KIND_FIXED;
        meta.fixed_angle = (dye7 > 0) ? ascta_pkg::ANG_270 : ascta_pkg::ANG_90;
      end else begin
        meta.kind  = ascta_pkg::KIND_CHORD;
        mag_a      = RW'(dxe7[DW1-1] ? DW1'(-dxe7) : DW1'(dxe7));
        mag_b      = RW'(dye7[DW1-1] ? DW1'(-dye7) : DW1'(dye7));
        meta.x_neg = dxe7[DW1-1];
        meta.y_neg = dye7[DW1-1];
      end
    end else if (lvl7_r) begin
      meta.kind        = ascta_pkg::KIND_FIXED;
      meta.fixed_angle = c7_r.vyg ? ascta_pkg::ANG_90 : ascta_pkg::ANG_270;
    end else if (abv7_r) begin
      meta.kind        = ascta_pkg::KIND_FIXED;
      meta.fixed_angle = c7_r.vxg ? ascta_pkg::ANG_0 : ascta_pkg::ANG_180;
    end else begin
      meta.kind  = ascta_pkg::KIND_RADIUS;
      mag_a      = arx7_r;
      mag_b      = ary7_r;
      meta.x_neg = uxn7_r;
      meta.y_neg = uyn7_r;
    end
  end

endmodule

@@ sv/ascta_norm.sv @@
// ----------------------------------------------------------------------------
// ascta_norm: joint magnitude normalizer
// Two stages: find the leading one of both magnitudes, then shift both so
// that it lands on the top bit of a 30-bit word (floor on right shifts).
// ----------------------------------------------------------------------------
module ascta_norm #(
  parameter int VW  = 53,
  parameter int SBW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [VW-1:0]                       a,
  input  logic [VW-1:0]                       b,
  input  logic [SBW-1:0]                      sb_in,
  output logic                                out_valid,
  output logic [ascta_pkg::NORM_BITS-1:0]     nx,
  output logic [ascta_pkg::NORM_BITS-1:0]     ny,
  output logic [SBW-1:0]                      sb_out
);

  localparam int NB = ascta_pkg::NORM_BITS;
  localparam int PW = $clog2(VW);

  // stage 1: leading-one position
  logic [VW-1:0] ab_or;
  logic [PW-1:0] pos_nxt;

  assign ab_or = a | b;

  always_comb begin
    pos_nxt = '0;
    for (int k = 0; k < VW; k++) begin
      if (ab_or[k]) pos_nxt = PW'(k);
    end
  end

  logic          v1_r;
  logic [VW-1:0] a_r, b_r;
  logic [PW-1:0] pos_r;
  logic [SBW-1:0] sb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a;
      b_r   <= b;
      pos_r <= pos_nxt;
      sb1_r <= sb_in;
    end
  end

  // stage 2: aligned shift, leading one to bit NB-1
  logic [PW:0]      sh;
  logic [VW+NB-1:0] ea, eb;
  logic [NB-1:0]    nx_nxt, ny_nxt;

  always_comb begin
    sh     = (PW+1)'(pos_r) + (PW+1)'(1);
    ea     = {a_r, NB'(0)} >> sh;
    eb     = {b_r, NB'(0)} >> sh;
    nx_nxt = ea[NB-1:0];
    ny_nxt = eb[NB-1:0];
  end

  logic v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx     <= nx_nxt;
      ny     <= ny_nxt;
      sb_out <= sb1_r;
    end
  end

  assign out_valid = v2_r;

endmodule

@@ sv/ascta_cordic.sv @@
// ----------------------------------------------------------------------------
// ascta_cordic: vectoring arctangent pipeline
// One registered stage per iteration; rotates (x, y) toward the x axis and
// accumulates the angle from the step table. Sideband rides alongside.
// ----------------------------------------------------------------------------
module ascta_cordic #(
  parameter int SBW = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [ascta_pkg::NORM_BITS-1:0]      x,
  input  logic [ascta_pkg::NORM_BITS-1:0]      y,
  input  logic [SBW-1:0]                       sb_in,
  output logic                                 out_valid,
  output logic signed [ascta_pkg::ZW-1:0]      z,
  output logic [SBW-1:0]                       sb_out
);

  localparam int N  = ascta_pkg::CORDIC_STEPS;
  localparam int XW = ascta_pkg::NORM_BITS + 3;
  localparam int ZW = ascta_pkg::ZW;

  logic                 v_r  [N];
  logic signed [XW-1:0] x_r  [N];
  logic signed [XW-1:0] y_r  [N];
  logic signed [ZW-1:0] z_r  [N];
  logic [SBW-1:0]       sb_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                 vi;
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    logic [SBW-1:0]       sbi;

    if (i == 0) begin : g_first
      assign vi  = in_valid;
      assign xi  = XW'(x);
      assign yi  = XW'(y);
      assign zi  = '0;
      assign sbi = sb_in;
    end else begin : g_next
      assign vi  = v_r[i-1];
      assign xi  = x_r[i-1];
      assign yi  = y_r[i-1];
      assign zi  = z_r[i-1];
      assign sbi = sb_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else if (en) v_r[i] <= vi;
    end

    // rotate down while y is positive, else up
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i] <= sbi;
        if (yi > 0) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ascta_pkg::ATAN_TAB[i];
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ascta_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign z         = z_r[N-1];
  assign sb_out    = sb_r[N-1];

endmodule

@@ sv/arc_start_tangent_angle.sv @@
// ----------------------------------------------------------------------------
// arc_start_tangent_angle: tangent direction at the start of a 3-point arc
// Solves the circumcircle centre and returns the start tangent angle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per point triple; in_tdata holds start_x, start_y,
//           via_x, via_y, end_x, end_y, COORD_BITS each, low bits first.
//   out_* : one word per triple, tangent angle in hundredths of a degree,
//           signed, -27000..27000, in the same order as the inputs.
// Throughput: one triple per cycle while out_tready stays high.
// Pipeline from input accept to out_tvalid: 7 front stages, queue,
//   1 fetch stage, 2 normalize stages, 2 side stages, 25 arctangent
//   stages, output register.
// The front and back pipelines are split by a 4-word queue; the back end
// holds while a result waits on out_tready, the front keeps taking words
// until the queue fills, then drops in_tready.
// Reset (rst_n low, synchronous) empties all pipelines and the queue; no
// result is pending afterwards.
// ----------------------------------------------------------------------------
module arc_start_tangent_angle #(
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // start_x, start_y, via_x, via_y, end_x, end_y (low to high)
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // tangent_angle
  output logic [15:0]                             out_tdata
);

  localparam int C      = COORD_BITS;
  localparam int DW1    = C + 1;
  localparam int RW     = 3*C + 5;
  localparam int NB     = ascta_pkg::NORM_BITS;
  localparam int META_W = $bits(ascta_pkg::meta_t);
  localparam int QW     = META_W + 2*DW1 + 2*RW;
  localparam int SB1W   = META_W + 2*DW1;
  localparam int PDW    = DW1 + NB + 1;
  localparam int ZW     = ascta_pkg::ZW;
  localparam int AW     = ascta_pkg::ANGLE_W;

  // field unpack
  logic signed [C-1:0] start_x, start_y, via_x, via_y, end_x, end_y;

  assign start_x = $signed(in_tdata[C-1:0]);
  assign start_y = $signed(in_tdata[2*C-1:C]);
  assign via_x   = $signed(in_tdata[3*C-1:2*C]);
  assign via_y   = $signed(in_tdata[4*C-1:3*C]);
  assign end_x   = $signed(in_tdata[5*C-1:4*C]);
  assign end_y   = $signed(in_tdata[6*C-1:5*C]);

  // front end
  logic                  q_push, q_pop, q_full, q_empty;
  ascta_pkg::meta_t      f_meta;
  logic signed [DW1-1:0] f_wx, f_wy;
  logic [RW-1:0]         f_a, f_b;
  logic [QW-1:0]         q_din, q_dout;

  ascta_front #(.COORD_BITS(C)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .start_x  (start_x),
    .start_y  (start_y),
    .via_x    (via_x),
    .via_y    (via_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .meta     (f_meta),
    .wx       (f_wx),
    .wy       (f_wy),
    .mag_a    (f_a),
    .mag_b    (f_b)
  );

  assign q_din = {f_meta, f_wx, f_wy, f_a, f_b};

  ascta_fifo #(.W(QW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // back end advances whenever the output register can move
  logic be;
  logic out_valid_r;
  logic [AW-1:0] out_data_r;

  assign be    = !out_valid_r || out_tready;
  assign q_pop = be && !q_empty;

  // fetch stage
  logic                  b0_v_r;
  ascta_pkg::meta_t      b0_meta_r;
  logic signed [DW1-1:0] b0_wx_r, b0_wy_r;
  logic [RW-1:0]         b0_a_r, b0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b0_v_r <= 1'b0;
    else if (be) b0_v_r <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (be) {b0_meta_r, b0_wx_r, b0_wy_r, b0_a_r, b0_b_r} <= q_dout;
  end

  // normalize
  logic             n_v;
  logic [NB-1:0]    n_x, n_y;
  logic [SB1W-1:0]  n_sb;

  ascta_norm #(.VW(RW), .SBW(SB1W)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (be),
    .in_valid  (b0_v_r),
    .a         (b0_a_r),
    .b         (b0_b_r),
    .sb_in     ({b0_meta_r, b0_wx_r, b0_wy_r}),
    .out_valid (n_v),
    .nx        (n_x),
    .ny        (n_y),
    .sb_out    (n_sb)
  );

  // side stage 1: cross products of via offset and signed direction
  ascta_pkg::meta_t      n_meta;
  logic signed [DW1-1:0] n_wx, n_wy;
  logic signed [NB:0]    snx, sny;

  assign {n_meta, n_wx, n_wy} = n_sb;

  always_comb begin
    snx = $signed({1'b0, n_x});
    sny = $signed({1'b0, n_y});
    if (n_meta.x_neg) snx = -snx;
    if (n_meta.y_neg) sny = -sny;
  end

  logic                  s1_v_r;
  ascta_pkg::meta_t      s1_meta_r;
  logic [NB-1:0]         s1_x_r, s1_y_r;
  logic signed [PDW-1:0] pa_r, pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (be) s1_v_r <= n_v;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      s1_meta_r <= n_meta;
      s1_x_r    <= n_x;
      s1_y_r    <= n_y;
      pa_r      <= PDW'(n_wx) * PDW'(sny);
      pb_r      <= PDW'(n_wy) * PDW'(snx);
    end
  end

  // side stage 2: which side of the radius the via point lies on
  logic signed [PDW:0] dot;
  ascta_pkg::meta_t    s1_meta_upd;

  always_comb begin
    dot                 = (PDW+1)'(pa_r) - (PDW+1)'(pb_r);
    s1_meta_upd         = s1_meta_r;
    s1_meta_upd.dot_pos = !dot[PDW] && (dot != '0);
  end

  logic             s2_v_r;
  ascta_pkg::meta_t s2_meta_r;
  logic [NB-1:0]    s2_x_r, s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (be) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      s2_meta_r <= s1_meta_upd;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
    end
  end

  // arctangent
  logic                 c_v;
  logic signed [ZW-1:0] c_z;
  logic [META_W-1:0]    c_sb;

  ascta_cordic #(.SBW(META_W)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (be),
    .in_valid  (s2_v_r),
    .x         (s2_x_r),
    .y         (s2_y_r),
    .sb_in     (s2_meta_r),
    .out_valid (c_v),
    .z         (c_z),
    .sb_out    (c_sb)
  );

  // round to hundredths and map to the final angle
  ascta_pkg::meta_t     c_meta;
  logic signed [ZW-1:0] zc, zr;
  logic signed [AW-1:0] q, a_c, theta, res;

  assign c_meta = c_sb;

  always_comb begin
    if (c_z < 0)                       zc = '0;
    else if (c_z > ascta_pkg::Z_MAX)   zc = ascta_pkg::Z_MAX;
    else                               zc = c_z;
    zr    = zc + ascta_pkg::Z_ROUND;
    q     = $signed({2'b00, zr[29:16]});
    a_c   = c_meta.y_neg ? -q : q;
    theta = c_meta.x_neg ? (c_meta.y_neg ? q - ascta_pkg::ANG_180 : ascta_pkg::ANG_180 - q)
                         : (c_meta.y_neg ? -q : q);
    case (c_meta.kind)
      ascta_pkg::KIND_FIXED:  res = c_meta.fixed_angle;
      ascta_pkg::KIND_CHORD:  res = c_meta.x_neg ? ascta_pkg::ANG_180 + a_c : -a_c;
      ascta_pkg::KIND_RADIUS: res = c_meta.dot_pos ? theta - ascta_pkg::ANG_90
                                                   : theta + ascta_pkg::ANG_90;
      default:                res = c_meta.fixed_angle;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (be) out_valid_r <= c_v;
  end

  always_ff @(posedge clk) begin
    if (be) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/ascta_chk.sv @@
// ----------------------------------------------------------------------------
// ascta_chk: port-level checks for the arc start tangent block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ascta_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // angle always within the legal span
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) >= -16'sd27000) && ($signed(out_tdata) <= 16'sd27000))
    else $error("tangent angle out of range");

  // reset leaves nothing pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // input backpressure only follows an output stall
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

endmodule

bind arc_start_tangent_angle ascta_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/arc_start_tangent_angle_tb.sv @@
// ----------------------------------------------------------------------------
// arc_start_tangent_angle_tb: self-checking bench for the arc tangent block
// Drives point triples over the input stream, computes the tangent angle of
// each with an exact integer circumcircle solver and a bit-true arctangent,
// and compares every output word in order against the expected angles.
// ----------------------------------------------------------------------------
module arc_start_tangent_angle_tb;

  localparam int CB      = 16;
  localparam int DW      = ((6*CB+7)/8)*8;
  localparam int N_RAND  = 450;
  localparam int WD_MAX  = 4000;

  // one directed row: six coordinates, whether the angle is typed in, and it
  typedef struct {
    logic signed [15:0] c [6];
    bit                 known;
    logic signed [15:0] angle;
  } row_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [DW-1:0] in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [15:0]   out_tdata;

  logic signed [15:0] angle_q [$];
  int   n_err;
  int   idle_cnt;
  bit   sending_done;
  bit   rx_hold;
  bit   quiet_mode;
  row_t rows [$];

  arc_start_tangent_angle #(.COORD_BITS(CB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // angle math
  // --------------------------------------------------------------------------
  function automatic logic signed [127:0] abs128(logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // shift both magnitudes into the cordic input range
  function automatic void scale_pair(input logic [127:0] a, input logic [127:0] b,
                                     output longint na, output longint nb);
    while (a >= (128'd1 << 30) || b >= (128'd1 << 30)) begin
      a = a >> 1;
      b = b >> 1;
    end
    if (a != 0 || b != 0)
      while (a < (128'd1 << 29) && b < (128'd1 << 29)) begin
        a = a << 1;
        b = b << 1;
      end
    na = longint'(a[63:0]);
    nb = longint'(b[63:0]);
  endfunction

  // first-quadrant arctangent in hundredths, vectoring mode
  function automatic longint atan_q1(longint x, longint y);
    longint z, ddx, ddy;
    z = 0;
    for (int i = 0; i < ascta_pkg::CORDIC_STEPS; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (y > 0) begin
        x += ddx; y -= ddy; z += longint'(ascta_pkg::ATAN_TAB[i]);
      end else begin
        x -= ddx; y += ddy; z -= longint'(ascta_pkg::ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(ascta_pkg::Z_MAX)) z = longint'(ascta_pkg::Z_MAX);
    return (z + 32768) >>> 16;
  endfunction

  function automatic longint chord_dir(longint dx, longint dy);
    longint nx, ny, b, a;
    if (dx == 0) return dy > 0 ? 27000 : 9000;
    scale_pair(128'(dx < 0 ? -dx : dx), 128'(dy < 0 ? -dy : dy), nx, ny);
    b = atan_q1(nx, ny);
    a = dy >= 0 ? b : -b;
    return dx > 0 ? -a : 18000 + a;
  endfunction

  function automatic logic signed [15:0] tangent_angle(logic signed [15:0] c [6]);
    longint sx, sy, vx, vy, ex, ey, s1x, s1y, s2x, s2y, nx, ny, q, th, wx, wy;
    logic signed [127:0] d, n, rx, ry, ad, ux, uy, dot;
    sx = longint'(c[0]); sy = longint'(c[1]); vx = longint'(c[2]);
    vy = longint'(c[3]); ex = longint'(c[4]); ey = longint'(c[5]);
    if (sx == ex) begin s1x = 1; s1y = 0; end
    else if (sy == ey) begin s1x = 0; s1y = 1; end
    else begin s1x = ey - sy; s1y = sx - ex; end
    if (vx == ex) begin s2x = 1; s2y = 0; end
    else if (vy == ey) begin s2x = 0; s2y = 1; end
    else begin s2x = ey - vy; s2y = vx - ex; end
    d  = 128'(s1x) * 128'(s2y) - 128'(s1y) * 128'(s2x);
    ad = abs128(d);
    if (d == 0) return 16'(chord_dir(ex - sx, ey - sy));
    if (sx != ex && sy != ey && vx != ex && ad * 100000000 < abs128(128'(s1y)))
      return 16'(chord_dir(ex - sx, ey - sy));
    n  = 128'(vx - sx) * 128'(s2y) - 128'(vy - sy) * 128'(s2x);
    rx = d * 128'(ex - sx) + n * 128'(s1x);
    ry = d * 128'(ey - sy) + n * 128'(s1y);
    // centre level with, then straight above or below the start point
    if (abs128(ry) * 500000 < ad) return vy > sy ? ascta_pkg::ANG_90 : ascta_pkg::ANG_270;
    if (abs128(rx) * 500000 < ad) return vx > sx ? ascta_pkg::ANG_0 : ascta_pkg::ANG_180;
    if (d < 0) begin ux = rx; uy = -ry; end
    else begin ux = -rx; uy = ry; end
    scale_pair(abs128(ux), abs128(uy), nx, ny);
    q = atan_q1(nx, ny);
    if (ux >= 0) th = uy < 0 ? -q : q;
    else th = uy < 0 ? q - 18000 : 18000 - q;
    if (ux < 0) nx = -nx;
    if (uy < 0) ny = -ny;
    wx = vx - sx;
    wy = sy - vy;
    if (wx == 0 && wy == 0) wx = 1;
    dot = 128'(wx) * 128'(ny) - 128'(wy) * 128'(nx);
    return 16'(dot > 0 ? th - 9000 : th + 9000);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic row_t mk_row(int a, int b, int cc, int dd, int e, int f,
                                  bit known = 0, int ang = 0);
    row_t r;
    r.c[0] = 16'(a); r.c[1] = 16'(b); r.c[2] = 16'(cc);
    r.c[3] = 16'(dd); r.c[4] = 16'(e); r.c[5] = 16'(f);
    r.known = known;
    r.angle = 16'(ang);
    return r;
  endfunction

  function automatic int rnd_coord(int mode);
    case (mode)
      0:       return int'($signed(16'($urandom)));
      1:       return int'($urandom_range(0, 200)) - 100;
      default: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                           : -32768 + int'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  task automatic send_word(row_t r);
    logic signed [15:0] want;
    // random idle before the word
    while (!quiet_mode && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    want = tangent_angle(r.c);
    if (r.known && want != r.angle)
      report_mismatch("predictor vs table", int'(want), int'(r.angle));
    in_tdata  <= {r.c[5], r.c[4], r.c[3], r.c[2], r.c[1], r.c[0]};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angle_q.push_back(r.known ? r.angle : want);
  endtask

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  initial begin
    row_t r;
    int   mode;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    n_err = 0;
    sending_done = 0;
    rx_hold = 0;
    quiet_mode = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: degenerate, axis, chord and extreme cases
    rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 9000));           // all equal
    rows.push_back(mk_row(0, 0, 5, 0, 10, 0, 1, 0));             // collinear horizontal
    rows.push_back(mk_row(10, 0, 5, 0, 0, 0, 1, 18000));         // chord leftward
    rows.push_back(mk_row(0, 0, 0, 5, 0, 10, 1, 27000));         // chord straight down
    rows.push_back(mk_row(0, 10, 0, 5, 0, 0, 1, 9000));          // chord straight up
    rows.push_back(mk_row(0, 0, 10, 10, 20, 0));                 // centre level with start
    rows.push_back(mk_row(0, 0, 10, -10, 20, 0));
    rows.push_back(mk_row(-10, 0, 0, 10, 10, 0));                // semicircle
    rows.push_back(mk_row(0, -10, 10, 0, 0, 10));                // centre straight above or below start
    rows.push_back(mk_row(0, -10, -10, 0, 0, 10));
    rows.push_back(mk_row(-10, 0, 0, 10, 10, 0));
    rows.push_back(mk_row(3, 7, 3, 7, 9, -2));                   // via equals start
    rows.push_back(mk_row(1, 1, 2, 2, 3, 3));                    // collinear diagonal
    rows.push_back(mk_row(-32768, -32768, 0, 32767, 32767, -32768));
    rows.push_back(mk_row(32767, 32767, -32768, 0, -32768, 32767));
    rows.push_back(mk_row(-32768, 32767, 32767, 32767, 32767, -32768));
    rows.push_back(mk_row(-32768, 0, 0, 1, 32767, 0));           // very flat arc
    rows.push_back(mk_row(-32768, -32768, 32766, 32767, 32767, 32767)); // near parallel
    rows.push_back(mk_row(-32768, -32767, 0, 0, 32767, 32767));
    rows.push_back(mk_row(5, 3, 5, -4, 5, 9));
    rows.push_back(mk_row(-1, -1, -1, 0, 0, -1));
    rows.push_back(mk_row(100, 0, 0, 100, -100, 0));
    foreach (rows[i]) send_word(rows[i]);

    // random triples, with no idling for triples 100 to 179
    for (int i = 0; i < N_RAND; i++) begin
      quiet_mode = (i >= 100 && i < 180);
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 6; k++)
        r.c[k] = 16'(rnd_coord(mode < 5 ? 0 : (mode < 8 ? 1 : 2)));
      // a few degenerate shapes: shared coordinates
      if (mode == 9) r.c[2 * $urandom_range(1, 2) + $urandom_range(0, 1)] = r.c[$urandom_range(0, 1)];
      r.known = 0;
      send_word(r);
    end
    in_tvalid <= 1'b0;
    sending_done = 1;
  end

  // --------------------------------------------------------------------------
  // receiver with random stalls and one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold) out_tready <= 1'b0;
      else out_tready <= quiet_mode || $urandom_range(0, 99) >= 13;
    end
  end

  initial begin
    wait (angle_q.size() > 40);
    @(posedge clk);
    rx_hold = 1;
    repeat (120) @(posedge clk);
    rx_hold = 0;
  end

  // --------------------------------------------------------------------------
  // output check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_q.size() == 0)
        report_mismatch("unexpected word", int'($signed(out_tdata)), 0);
      else begin
        if ($signed(out_tdata) !== angle_q[0])
          report_mismatch("tangent_angle", int'($signed(out_tdata)), int'(angle_q[0]));
        void'(angle_q.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog and end of run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
  end

  initial begin
    idle_cnt = 0;
    @(posedge rst_n);
    fork
      begin
        wait (idle_cnt >= WD_MAX);
        $display("arc_start_tangent_angle verification failed");
        $finish;
      end
      begin
        wait (sending_done && angle_q.size() == 0);
        repeat (60) @(posedge clk);
        if (n_err == 0) $display("arc_start_tangent_angle verification clean");
        else $display("arc_start_tangent_angle verification failed");
        $finish;
      end
    join
  end

endmodule

@@ arc_start_tangent_angle.f @@
sv/ascta_pkg.sv
sv/ascta_fifo.sv
sv/ascta_front.sv
sv/ascta_norm.sv
sv/ascta_cordic.sv
sv/arc_start_tangent_angle.sv
sv/ascta_chk.sv
tb/sv/arc_start_tangent_angle_tb.sv
